[rtl/tmsf_pkg.sv]
// ----------------------------------------------------------------------------
// tmsf_pkg
// Shared constants, types and state codes of the trimmed-mean spike filter.
// ----------------------------------------------------------------------------
package tmsf_pkg;

  // Window depth and the widths derived from it.
  localparam int unsigned Window  = 5;
  localparam int unsigned DataW   = 8;
  localparam int unsigned IdxW    = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned SumW    = $clog2(Window * 255 + 1);
  localparam int unsigned Divisor = Window - 2;
  localparam int unsigned QuotW   = DataW;

  // Rounded-up reciprocal of the divisor. Multiplying a trimmed sum below
  // 2**SumW by it and dropping RecipShift bits gives the exact truncated
  // quotient. The product always fits in ProdW bits since the mean is a byte.
  localparam int unsigned RecipShift = SumW + $clog2(Divisor);
  localparam int unsigned RecipMul   = ((1 << RecipShift) + Divisor - 1) / Divisor;
  localparam int unsigned ProdW      = RecipShift + QuotW;

  localparam logic [DataW-1:0] ZeroMotion      = 8'd127;
  localparam logic [DataW-1:0] SpikeLimitReset = 8'd10;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StWalk   = 4'b0010,
    StDiv    = 4'b0100,
    StUpdate = 4'b1000
  } tmsf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic walk;
    logic div;
    logic update;
  } tmsf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_last;
  } tmsf_status_t;

endpackage

[rtl/tmsf_if.sv]
// ----------------------------------------------------------------------------
// tmsf_if
// Valid/ready channels carrying sample beats in and filtered beats out.
// ----------------------------------------------------------------------------
interface tmsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_sample;
  logic [7:0] y_sample;

  modport source (output valid, output x_sample, output y_sample, input ready);
  modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

interface tmsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_filtered;
  logic [7:0] y_filtered;
  logic       x_accepted;
  logic       y_accepted;

  modport source (output valid, output x_filtered, output y_filtered,
                  output x_accepted, output y_accepted, input ready);
  modport sink   (input valid, input x_filtered, input y_filtered,
                  input x_accepted, input y_accepted, output ready);
endinterface

[rtl/tmsf_ctrl.sv]
// ----------------------------------------------------------------------------
// tmsf_ctrl
// Sequencer: accept, window walk, divide, update, and the output valid flag.
// ----------------------------------------------------------------------------
module tmsf_ctrl
  import tmsf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  tmsf_status_t status_i,
  output tmsf_cmd_t    cmd_o
);

  tmsf_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The output register is free when empty or being drained this cycle.
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    out_valid_d     = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StWalk;
        end
      end
      StWalk: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_last) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div = 1'b1;
        state_d   = StUpdate;
      end
      StUpdate: begin
        if (out_free) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/tmsf_datapath.sv]
// ----------------------------------------------------------------------------
// tmsf_datapath
// Sample windows, sum/max/min accumulators, reciprocal divider, held outputs.
// ----------------------------------------------------------------------------
module tmsf_datapath
  import tmsf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tmsf_cmd_t        cmd_i,
  output tmsf_status_t     status_o,
  input  logic             cfg_we_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  input  logic [DataW-1:0] x_sample_i,
  input  logic [DataW-1:0] y_sample_i,
  output logic [DataW-1:0] x_filtered_o,
  output logic [DataW-1:0] y_filtered_o,
  output logic             x_accepted_o,
  output logic             y_accepted_o
);

  logic [DataW-1:0] x_win_q [Window];
  logic [DataW-1:0] y_win_q [Window];
  logic [IdxW-1:0]  slot_q, slot_idx;
  logic [IdxW-1:0]  walk_q;
  logic [SumW-1:0]  x_sum_q, y_sum_q, x_trim, y_trim;
  logic [ProdW-1:0] x_prod, y_prod;
  logic [DataW-1:0] x_hi_q, x_lo_q, y_hi_q, y_lo_q;
  logic [QuotW-1:0] x_quot_q, y_quot_q;
  logic [DataW-1:0] x_held_q, y_held_q, spike_limit_q;
  logic [DataW-1:0] x_rd, y_rd, x_diff, y_diff;
  logic             x_acc, y_acc;
  logic [DataW-1:0] x_out_q, y_out_q;
  logic             x_acc_q, y_acc_q;

  // A slot past the window end is treated as slot zero.
  assign slot_idx = (32'(slot_q) >= Window) ? '0 : slot_q;

  assign status_o.walk_last = (32'(walk_q) == Window - 1);

  assign x_rd = x_win_q[walk_q];
  assign y_rd = y_win_q[walk_q];

  // Trimmed sums, divided by a multiply with the rounded-up reciprocal.
  assign x_trim = x_sum_q - SumW'(x_hi_q) - SumW'(x_lo_q);
  assign y_trim = y_sum_q - SumW'(y_hi_q) - SumW'(y_lo_q);
  assign x_prod = ProdW'(x_trim) * ProdW'(RecipMul);
  assign y_prod = ProdW'(y_trim) * ProdW'(RecipMul);

  // Spike test against the held value; a mean equal to ZeroMotion always passes.
  always_comb begin
    x_diff = (x_quot_q >= x_held_q) ? (x_quot_q - x_held_q) : (x_held_q - x_quot_q);
    y_diff = (y_quot_q >= y_held_q) ? (y_quot_q - y_held_q) : (y_held_q - y_quot_q);
    x_acc  = (x_diff < spike_limit_q) || (x_quot_q == ZeroMotion);
    y_acc  = (y_diff < spike_limit_q) || (y_quot_q == ZeroMotion);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) begin
        x_win_q[i] <= '0;
        y_win_q[i] <= '0;
      end
      slot_q        <= '0;
      walk_q        <= '0;
      x_held_q      <= '0;
      y_held_q      <= '0;
      spike_limit_q <= SpikeLimitReset;
    end else begin
      if (cfg_we_i) begin
        spike_limit_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        x_win_q[slot_idx] <= x_sample_i;
        y_win_q[slot_idx] <= y_sample_i;
        slot_q <= (32'(slot_idx) == Window - 1) ? '0 : slot_idx + IdxW'(1);
        walk_q <= '0;
      end
      if (cmd_i.walk) begin
        walk_q <= status_o.walk_last ? '0 : walk_q + IdxW'(1);
      end
      if (cmd_i.update) begin
        if (x_acc) begin
          x_held_q <= x_quot_q;
        end
        if (y_acc) begin
          y_held_q <= y_quot_q;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_sum_q <= '0;
      y_sum_q <= '0;
      x_hi_q  <= '0;
      y_hi_q  <= '0;
      x_lo_q  <= '1;
      y_lo_q  <= '1;
    end
    if (cmd_i.walk) begin
      x_sum_q <= x_sum_q + SumW'(x_rd);
      y_sum_q <= y_sum_q + SumW'(y_rd);
      if (x_rd > x_hi_q) x_hi_q <= x_rd;
      if (x_rd < x_lo_q) x_lo_q <= x_rd;
      if (y_rd > y_hi_q) y_hi_q <= y_rd;
      if (y_rd < y_lo_q) y_lo_q <= y_rd;
    end
    if (cmd_i.div) begin
      x_quot_q <= x_prod[RecipShift +: QuotW];
      y_quot_q <= y_prod[RecipShift +: QuotW];
    end
    if (cmd_i.update) begin
      x_out_q <= x_acc ? x_quot_q : x_held_q;
      y_out_q <= y_acc ? y_quot_q : y_held_q;
      x_acc_q <= x_acc;
      y_acc_q <= y_acc;
    end
  end

  assign x_filtered_o = x_out_q;
  assign y_filtered_o = y_out_q;
  assign x_accepted_o = x_acc_q;
  assign y_accepted_o = y_acc_q;

endmodule

[rtl/trimmed_mean_spike_filter_unit.sv]
// ----------------------------------------------------------------------------
// trimmed_mean_spike_filter_unit
// Two-axis trimmed-mean filter with spike rejection for motion samples.
// ----------------------------------------------------------------------------
// Usage: each input beat on in_i carries one x and one y sample in offset
// binary, where 127 stands for zero motion. For every input beat the unit
// delivers exactly one output beat on out_o with the held x and y values
// and a flag per axis that tells whether the new trimmed mean was taken.
// Both channels use valid/ready; a beat moves when both are high.
// An item passes these steps in order: the accepting cycle writes the window,
// the walk accumulates sum, largest and smallest over one window entry per
// cycle, the divide step forms the trimmed sum and divides it by a multiply
// with the reciprocal, and the update step updates the held values.
// The unit takes no new item while one is still in its walk, divide or
// update step.
// The output register decouples the sides: the next beat is accepted while
// a result still waits. If the receiver stalls, the unit holds the finished
// result in its update step until the output register frees up.
// Reset clears both windows, the slot pointer and the held values to zero
// and loads the spike limit with 10. The limit (cfg_we_i/cfg_wdata_i)
// must be written only while no item is in flight; no logic enforces this.
// ----------------------------------------------------------------------------
module trimmed_mean_spike_filter_unit
  import tmsf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  tmsf_in_if.sink          in_i,
  tmsf_out_if.source       out_o
);

  tmsf_cmd_t    cmd;
  tmsf_status_t status;

  // The sequencer owns the handshakes; the datapath owns all values.
  tmsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tmsf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .x_sample_i   (in_i.x_sample),
    .y_sample_i   (in_i.y_sample),
    .x_filtered_o (out_o.x_filtered),
    .y_filtered_o (out_o.y_filtered),
    .x_accepted_o (out_o.x_accepted),
    .y_accepted_o (out_o.y_accepted)
  );

endmodule
